FILE: rtl/poq_pkg.sv
package poq_pkg;

   localparam int ACT_W   = 3;
   localparam int PID_W   = 5;
   localparam int KEY_W   = 32;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 6;

   typedef logic [ACT_W-1:0]  action_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam action_type ACT_INSERT   = 3'd0;
   localparam action_type ACT_REM_HEAD = 3'd1;
   localparam action_type ACT_REM_TAIL = 3'd2;
   localparam action_type ACT_REM_PID  = 3'd3;
   localparam action_type ACT_LOOKUP   = 3'd4;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_EMPTY     = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_BAD_PID   = 3'd3;
   localparam status_type ST_NOT_FOUND = 3'd4;

   // One queue slot as it sits in the entry memory.
   typedef struct packed {
      logic [PID_W-1:0]        pid;
      logic signed [KEY_W-1:0] key;
   } entry_type;

endpackage

FILE: rtl/priority_ordered_process_queue.sv
// Channel   | Ports                                   | Direction | Handshake
// ----------+-----------------------------------------+-----------+---------------------------
// request   | req_action, req_proc_id, req_prio_key   | in        | start high while busy low
// response  | rsp_status, rsp_result_pid, rsp_result_key,
//           | rsp_entry_count, rsp_is_empty, rsp_is_full | out    | rsp_valid, one cycle
//
// Rejected requests, reserved actions and an insert into an empty queue are answered in the
// cycle after the request beat without raising busy. An insert stays busy while each entry
// with a lower key moves one slot toward the tail, and while the new entry is written.
// A removal or look-up stays busy while it scans slots, and a removal also while the later
// entries move toward the head. The entry memory has one read port and one write port:
// one slot is read and one written in each cycle. Reset is synchronous and empties the queue
// at once. The receiver cannot stall: each response beat is shown for exactly one cycle.
module priority_ordered_process_queue #(
   parameter int CAPACITY = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [poq_pkg::ACT_W-1:0]           req_action,
   input  logic [poq_pkg::PID_W-1:0]           req_proc_id,
   input  logic signed [poq_pkg::KEY_W-1:0]    req_prio_key,
   output logic                                rsp_valid,
   output logic [poq_pkg::STAT_W-1:0]          rsp_status,
   output logic [poq_pkg::PID_W-1:0]           rsp_result_pid,
   output logic signed [poq_pkg::KEY_W-1:0]    rsp_result_key,
   output logic [poq_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full
);
   import poq_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = CNT_W + PID_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS_PUT,
      S_SRCH,
      S_SHIFT
   } state_type;

   // The entries live in one memory, head at slot zero, in descending key order.
   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;

   state_type          state_ff, state_in;
   action_type         act_ff, act_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   cnt_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [PID_W-1:0]   rsp_pid_ff;
   logic signed [KEY_W-1:0] rsp_key_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;

   // A finishing request: what the response beat carries and the new entry count.
   logic               fin;
   status_type         fin_status;
   logic [PID_W-1:0]   fin_pid;
   logic signed [KEY_W-1:0] fin_key;
   logic [CNT_W-1:0]   fin_cnt;

   logic               accept;
   logic               full;
   logic               pid_bad;
   logic               hit;
   logic               gt;
   logic [CNT_W:0]     cnt_x;
   logic [CNT_W:0]     ptr_p1;
   logic [CNT_W:0]     ptr_p2;
   logic [CNT_W-1:0]   ptr_m1;
   logic [CNT_W-1:0]   ptr_m2;
   logic [CNT_W-1:0]   cnt_m1;
   logic [CNT_W-1:0]   cnt_p1;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;
   entry_type          new_entry;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign full    = (cnt_ff == CNT_W'(CAPACITY));
   assign pid_bad = (CMP_W'(req_proc_id) >= CMP_W'(CAPACITY));
   assign cnt_x   = {1'b0, cnt_ff};
   assign ptr_p1  = {1'b0, ptr_ff} + (CNT_W + 1)'(1);
   assign ptr_p2  = {1'b0, ptr_ff} + (CNT_W + 1)'(2);
   assign ptr_m1  = ptr_ff - CNT_W'(1);
   assign ptr_m2  = ptr_ff - CNT_W'(2);
   assign cnt_m1  = cnt_ff - CNT_W'(1);
   assign cnt_p1  = cnt_ff + CNT_W'(1);
   assign gt      = (key_ff > rd_data_ff.key);
   assign hit     = (act_ff == ACT_REM_HEAD) || (act_ff == ACT_REM_TAIL) ||
                    (rd_data_ff.pid == pid_ff);
   assign new_entry = '{pid: pid_ff, key: key_ff};

   // Sequencer. An insert walks from the tail toward the head, moving each lower key one
   // slot back until the new entry's place is found; equal keys stay ahead of it. A removal
   // scans from the head (or reads the tail), then pulls the later entries forward by one.
   // Each step reads one slot and writes a different one, so the memory never sees a read
   // and a write of the same slot in one cycle and no forwarding is needed.
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      pid_in      = pid_ff;
      key_in      = key_ff;
      ptr_in      = ptr_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff[ADDR_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff[ADDR_W-1:0];
      mem_wr_data = rd_data_ff;
      fin         = 1'b0;
      fin_status  = ST_OK;
      fin_pid     = '0;
      fin_key     = '0;
      fin_cnt     = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in = req_action;
               pid_in = req_proc_id;
               key_in = req_prio_key;
               case (req_action)
                  ACT_INSERT: begin
                     if (full) begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                     end else if (pid_bad) begin
                        fin        = 1'b1;
                        fin_status = ST_BAD_PID;
                     end else if (cnt_ff == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = '{pid: req_proc_id, key: req_prio_key};
                        fin         = 1'b1;
                        fin_pid     = req_proc_id;
                        fin_cnt     = cnt_p1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cnt_m1[ADDR_W-1:0];
                        ptr_in      = cnt_ff;
                        state_in    = S_INS;
                     end
                  end
                  ACT_REM_HEAD, ACT_REM_PID, ACT_LOOKUP: begin
                     if (cnt_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        ptr_in      = '0;
                        state_in    = S_SRCH;
                     end
                  end
                  ACT_REM_TAIL: begin
                     if (cnt_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cnt_m1[ADDR_W-1:0];
                        ptr_in      = cnt_m1;
                        state_in    = S_SRCH;
                     end
                  end
                  default: begin
                     // Reserved actions change nothing and report success.
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_INS: begin
            // rd_data_ff holds the slot just ahead of ptr_ff.
            mem_wr_en = 1'b1;
            if (gt) begin
               mem_wr_data = rd_data_ff;
               ptr_in      = ptr_m1;
               if (ptr_ff == CNT_W'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_m2[ADDR_W-1:0];
               end
            end else begin
               mem_wr_data = new_entry;
               fin         = 1'b1;
               fin_pid     = pid_ff;
               fin_cnt     = cnt_p1;
               state_in    = S_IDLE;
            end
         end
         S_INS_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = new_entry;
            fin         = 1'b1;
            fin_pid     = pid_ff;
            fin_cnt     = cnt_p1;
            state_in    = S_IDLE;
         end
         S_SRCH: begin
            // rd_data_ff holds the slot at ptr_ff.
            if (hit) begin
               pid_in = rd_data_ff.pid;
               key_in = rd_data_ff.key;
               if (act_ff == ACT_LOOKUP || act_ff == ACT_REM_TAIL || ptr_p1 >= cnt_x) begin
                  fin      = 1'b1;
                  fin_pid  = rd_data_ff.pid;
                  fin_key  = rd_data_ff.key;
                  fin_cnt  = (act_ff == ACT_LOOKUP) ? cnt_ff : cnt_m1;
                  state_in = S_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_p1[ADDR_W-1:0];
                  state_in    = S_SHIFT;
               end
            end else if (ptr_p1 < cnt_x) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_p1[ADDR_W-1:0];
               ptr_in      = ptr_p1[CNT_W-1:0];
            end else begin
               fin        = 1'b1;
               fin_status = ST_NOT_FOUND;
               state_in   = S_IDLE;
            end
         end
         S_SHIFT: begin
            // rd_data_ff holds the slot behind ptr_ff; it moves one place forward.
            mem_wr_en   = 1'b1;
            mem_wr_data = rd_data_ff;
            ptr_in      = ptr_p1[CNT_W-1:0];
            if (ptr_p2 < cnt_x) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_p2[ADDR_W-1:0];
            end else begin
               fin      = 1'b1;
               fin_pid  = pid_ff;
               fin_key  = key_ff;
               fin_cnt  = cnt_m1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory: one write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin;
         if (fin) begin
            cnt_ff <= fin_cnt;
         end
      end
      act_ff <= act_in;
      pid_ff <= pid_in;
      key_ff <= key_in;
      ptr_ff <= ptr_in;
      if (fin) begin
         rsp_status_ff <= fin_status;
         rsp_pid_ff    <= fin_pid;
         rsp_key_ff    <= fin_key;
         rsp_cnt_ff    <= fin_cnt;
      end
   end

   assign cnt_ext         = {{COUNT_W{1'b0}}, rsp_cnt_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_pid  = rsp_pid_ff;
   assign rsp_result_key  = rsp_key_ff;
   assign rsp_entry_count = cnt_ext[COUNT_W-1:0];
   assign rsp_is_empty    = (rsp_cnt_ff == '0);
   assign rsp_is_full     = (rsp_cnt_ff == CNT_W'(CAPACITY));

   // The entry count never passes the capacity.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // The count only moves together with a response beat.
   a_cnt_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !$stable(cnt_ff) |-> rsp_valid_ff)
      else $error("entry count changed without a response");

   // A response follows either a busy cycle or a request beat answered at once.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept || busy))
      else $error("response without a request");

   // A sequencer write never targets the slot being read in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("entry memory read and write of one slot");

endmodule
